/* src/qebd_pkg.sv */
// shared constants and types for the quadrature encoder bank decoder
// no dependencies

package qebd_pkg;

   localparam int EncoderCount = 12;
   localparam int PhaseWidth   = 2;
   localparam int WordWidth    = 24;
   localparam int IndexWidth   = 4;

   localparam logic [1:0] PhaseLow  = 2'b00;
   localparam logic [1:0] PhaseHigh = 2'b11;
   localparam logic [1:0] PhaseA    = 2'b01;
   localparam logic [1:0] PhaseB    = 2'b10;

   typedef struct packed {
      logic step;
      logic dir;
   } lane_result_type;

   typedef struct packed {
      logic pend_empty;
      logic pop;
      logic final_pop;
   } merge_status_type;

endpackage

/* src/qebd_lane.sv */
// one encoder lane: stored phase and step classification
// depends on qebd_pkg

module qebd_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [1:0]              phase_now,
   output qebd_pkg::lane_result_type result
);

   logic [1:0] prev_ff;
   logic [1:0] prev_in;

   always_comb begin
      result.step = 1'b0;
      result.dir  = 1'b0;
      case (phase_now)
         qebd_pkg::PhaseLow: begin
            if (prev_ff == qebd_pkg::PhaseA) begin
               result.step = 1'b1;
            end else if (prev_ff == qebd_pkg::PhaseB) begin
               result.step = 1'b1;
               result.dir  = 1'b1;
            end
         end
         qebd_pkg::PhaseHigh: begin
            if (prev_ff == qebd_pkg::PhaseB) begin
               result.step = 1'b1;
            end else if (prev_ff == qebd_pkg::PhaseA) begin
               result.step = 1'b1;
               result.dir  = 1'b1;
            end
         end
         default: begin
            result.step = 1'b0;
            result.dir  = 1'b0;
         end
      endcase
   end

   assign prev_in = load ? phase_now : prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= qebd_pkg::PhaseLow;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

/* src/qebd_merge.sv */
// merging stage: pending event mask, lowest-first pick, output register
// depends on qebd_pkg

module qebd_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [qebd_pkg::EncoderCount-1:0]     load_mask,
   input  logic [qebd_pkg::EncoderCount-1:0]     load_dir,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [qebd_pkg::IndexWidth-1:0]       rsp_encoder_index,
   output logic                                  rsp_direction,
   output logic                                  rsp_last_event,
   output logic                                  can_load,
   output qebd_pkg::merge_status_type            status
);

   localparam int N = qebd_pkg::EncoderCount;

   logic [N-1:0]                    mask_ff, mask_in;
   logic [N-1:0]                    dir_ff, dir_in;
   logic                            valid_ff, valid_in;
   logic [qebd_pkg::IndexWidth-1:0] index_ff, index_in;
   logic                            direction_ff, direction_in;
   logic                            last_ff, last_in;

   logic [N-1:0]                    lowest;
   logic [N-1:0]                    remaining;
   logic [qebd_pkg::IndexWidth-1:0] pick_index;
   logic                            pick_dir;
   logic                            pend_empty;
   logic                            pop;
   logic                            final_pop;

   assign lowest     = mask_ff & (~mask_ff + N'(1));
   assign remaining  = mask_ff & ~lowest;
   assign pend_empty = (mask_ff == '0);
   assign pop        = !pend_empty && (!valid_ff || rsp_ready);
   assign final_pop  = pop && (remaining == '0);
   assign can_load   = pend_empty || final_pop;

   always_comb begin
      pick_index = '0;
      pick_dir   = 1'b0;
      for (int n = 0; n < N; n++) begin
         pick_index = pick_index | ({qebd_pkg::IndexWidth{lowest[n]}} & n[qebd_pkg::IndexWidth-1:0]);
         pick_dir   = pick_dir | (lowest[n] & dir_ff[n]);
      end
   end

   always_comb begin
      mask_in      = mask_ff;
      dir_in       = dir_ff;
      valid_in     = valid_ff;
      index_in     = index_ff;
      direction_in = direction_ff;
      last_in      = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         mask_in      = remaining;
         valid_in     = 1'b1;
         index_in     = pick_index;
         direction_in = pick_dir;
         last_in      = (remaining == '0);
      end
      if (load) begin
         mask_in = load_mask;
         dir_in  = load_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff       <= dir_in;
      index_ff     <= index_in;
      direction_ff <= direction_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_encoder_index = index_ff;
   assign rsp_direction     = direction_ff;
   assign rsp_last_event    = last_ff;

   assign status.pend_empty = pend_empty;
   assign status.pop        = pop;
   assign status.final_pop  = final_pop;

endmodule

/* src/quadrature_encoder_bank_decoder_core.sv */
// top level of the quadrature encoder bank decoder: twelve lanes and a merging stage
// depends on qebd_pkg, qebd_lane, qebd_merge
//
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_phase_word[23:0]
// rsp      out        rsp_valid/rsp_ready  rsp_encoder_index[3:0], rsp_direction, rsp_last_event
//
// all lanes classify a sample in its transfer cycle; one event leaves per cycle unless rsp stalls
// a sample's events leave the merging stage lowest lane first, one with none takes no slot
// the next sample is taken in the cycle the final pending event moves to the output register
// reset clears the stored phases, the pending mask and the output valid
// a stalled rsp holds its register; req is held off while more events wait to move up

module quadrature_encoder_bank_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [qebd_pkg::WordWidth-1:0]     req_phase_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [qebd_pkg::IndexWidth-1:0]    rsp_encoder_index,
   output logic                               rsp_direction,
   output logic                               rsp_last_event
);

   localparam int N = qebd_pkg::EncoderCount;

   logic                         accept;
   logic                         can_load;
   logic [N-1:0]                 step_mask;
   logic [N-1:0]                 step_dir;
   qebd_pkg::lane_result_type    lane_result [N];
   qebd_pkg::merge_status_type   status;

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   for (genvar n = 0; n < N; n++) begin : g_lane
      logic [1:0] phase_now;
      if ((n + 1) * qebd_pkg::PhaseWidth <= qebd_pkg::WordWidth) begin : g_in_word
         assign phase_now = req_phase_word[n*qebd_pkg::PhaseWidth +: qebd_pkg::PhaseWidth];
      end else begin : g_past_word
         assign phase_now = qebd_pkg::PhaseLow;
      end

      qebd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .phase_now (phase_now),
         .result    (lane_result[n])
      );

      assign step_mask[n] = lane_result[n].step;
      assign step_dir[n]  = lane_result[n].dir;
   end

   qebd_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .load_mask         (step_mask),
      .load_dir          (step_dir),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_encoder_index (rsp_encoder_index),
      .rsp_direction     (rsp_direction),
      .rsp_last_event    (rsp_last_event),
      .can_load          (can_load),
      .status            (status)
   );

`ifndef NO_ASSERTIONS
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_encoder_index < qebd_pkg::IndexWidth'(N)))
      else $error("encoder index out of range");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_event) |-> !status.pend_empty)
      else $error("non-final event without pending events");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (status.pend_empty || status.final_pop))
      else $error("sample taken over pending events");

   a_last_after_final: assert property (@(posedge clock) disable iff (reset)
      status.final_pop |=> (rsp_valid && rsp_last_event))
      else $error("final pick not marked last");
`endif

endmodule
